FILE: sv/dts_pkg.sv
// shared types, constants and codes for the depth-first topological sort block
package dts_pkg;

  // vertex numbering is fixed by the 6-bit vertex fields
  localparam int unsigned NumVerts    = 64;
  localparam int unsigned VertW       = 6;
  localparam int unsigned CntW        = 7;
  localparam int unsigned DefMaxEdges = 256;

  // request codes
  localparam logic ReqAddEdge = 1'b0;
  localparam logic ReqSort    = 1'b1;

  // register map
  localparam logic RegVertexCount = 1'b0;
  localparam logic [CntW-1:0] VertexCountReset = CntW'(NumVerts);

  // input item
  typedef struct packed {
    logic             req_type;
    logic [VertW-1:0] from_vertex;
    logic [VertW-1:0] to_vertex;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [VertW-1:0] vertex;
    logic             last;
    logic             edges_dropped;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_edge;
    logic clear_walk;
    logic root_next;
    logic root_start;
    logic fetch;
    logic descend;
    logic skip;
    logic finish;
    logic pop_rd;
    logic pop_ld;
    logic emit_rd;
    logic emit_ld;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic root_done;
    logic root_visited;
    logic scan_end;
    logic edge_hit;
    logic last_level;
    logic emit_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/dts_dp.sv
// datapath: edge store, visited marks, walk and finish stacks, output register
module dts_dp #(
  parameter int unsigned MAX_EDGES = dts_pkg::DefMaxEdges
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dts_pkg::in_item_t         in_item_i,
  input  logic [dts_pkg::CntW-1:0]  vcount_i,
  input  dts_pkg::dp_cmd_t          cmd_i,
  output dts_pkg::dp_sts_t          sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dts_pkg::out_item_t        out_item_o
);
  import dts_pkg::*;

  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam logic [ECW-1:0] EdgeCap = ECW'(MAX_EDGES);
  localparam logic [CntW-1:0] VertCap = CntW'(NumVerts);

  // memories
  logic [2*VertW-1:0]     edge_mem [MAX_EDGES];
  logic [VertW+ECW-1:0]   walk_mem [NumVerts];
  logic [VertW-1:0]       fin_mem  [NumVerts];

  // control state
  logic [NumVerts-1:0] visited_q;
  logic [ECW-1:0]      edge_cnt_q;
  logic                drop_q;
  logic [CntW-1:0]     depth_q;
  logic [CntW-1:0]     fin_q;
  logic [CntW-1:0]     root_q;
  logic                out_valid_q;

  // payload state
  logic [VertW-1:0]     top_v_q;
  logic [ECW-1:0]       top_e_q;
  logic [2*VertW-1:0]   edge_rd_q;
  logic [VertW+ECW-1:0] walk_rd_q;
  logic [VertW-1:0]     fin_rd_q;
  out_item_t            out_item_q;

  logic [CntW-1:0]  n_eff;
  logic             edge_ok;
  logic [VertW-1:0] edge_src;
  logic [VertW-1:0] edge_tgt;
  logic [ECW-1:0]   top_e_inc;
  logic [CntW-1:0]  depth_m1;
  logic [CntW-1:0]  fin_m1;
  logic             can_push;

  // effective vertex count, clamped to capacity
  assign n_eff = (vcount_i > VertCap) ? VertCap : vcount_i;

  assign edge_ok = (edge_cnt_q < EdgeCap) &&
                   (CntW'(in_item_i.from_vertex) < n_eff) &&
                   (CntW'(in_item_i.to_vertex) < n_eff);

  assign edge_src  = edge_rd_q[2*VertW-1:VertW];
  assign edge_tgt  = edge_rd_q[VertW-1:0];
  assign top_e_inc = top_e_q + ECW'(1);
  assign depth_m1  = depth_q - CntW'(1);
  assign fin_m1    = fin_q - CntW'(1);
  assign can_push  = depth_q < VertCap;

  // edge store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_edge && edge_ok) begin
      edge_mem[edge_cnt_q[EAW-1:0]] <= {in_item_i.from_vertex, in_item_i.to_vertex};
    end
    if (cmd_i.fetch) begin
      edge_rd_q <= edge_mem[top_e_q[EAW-1:0]];
    end
  end

  // walk stack, levels below the top
  always_ff @(posedge clk_i) begin
    if (cmd_i.descend && can_push) begin
      walk_mem[depth_m1[VertW-1:0]] <= {top_v_q, top_e_inc};
    end
    if (cmd_i.pop_rd) begin
      walk_rd_q <= walk_mem[depth_m1[VertW-1:0]];
    end
  end

  // finish stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && (fin_q < VertCap)) begin
      fin_mem[fin_q[VertW-1:0]] <= top_v_q;
    end
    if (cmd_i.emit_rd) begin
      fin_rd_q <= fin_mem[fin_m1[VertW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q   <= '0;
      edge_cnt_q  <= '0;
      drop_q      <= 1'b0;
      depth_q     <= '0;
      fin_q       <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_edge) begin
        if (edge_ok) begin
          edge_cnt_q <= edge_cnt_q + ECW'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.clear_walk) begin
        visited_q <= '0;
        root_q    <= '0;
        fin_q     <= '0;
      end
      if (cmd_i.root_next) begin
        root_q <= root_q + CntW'(1);
      end
      if (cmd_i.root_start) begin
        visited_q[root_q[VertW-1:0]] <= 1'b1;
        depth_q <= CntW'(1);
      end
      if (cmd_i.descend) begin
        visited_q[edge_tgt] <= 1'b1;
        if (can_push) begin
          depth_q <= depth_q + CntW'(1);
        end
      end
      if (cmd_i.finish) begin
        depth_q <= depth_m1;
        if (fin_q < VertCap) begin
          fin_q <= fin_q + CntW'(1);
        end
      end
      if (cmd_i.emit_rd) begin
        fin_q <= fin_m1;
      end
      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // top of walk stack and output item
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      top_v_q <= root_q[VertW-1:0];
      top_e_q <= '0;
    end
    if (cmd_i.descend) begin
      if (can_push) begin
        top_v_q <= edge_tgt;
        top_e_q <= '0;
      end else begin
        top_e_q <= top_e_inc;
      end
    end
    if (cmd_i.skip) begin
      top_e_q <= top_e_inc;
    end
    if (cmd_i.pop_ld) begin
      top_v_q <= walk_rd_q[VertW+ECW-1:ECW];
      top_e_q <= walk_rd_q[ECW-1:0];
    end
    if (cmd_i.emit_ld) begin
      out_item_q.vertex        <= fin_rd_q;
      out_item_q.last          <= (fin_q == '0);
      out_item_q.edges_dropped <= drop_q;
    end
  end

  // status back to the controller
  assign sts_o.root_done    = root_q >= n_eff;
  assign sts_o.root_visited = visited_q[root_q[VertW-1:0]];
  assign sts_o.scan_end     = top_e_q >= edge_cnt_q;
  assign sts_o.edge_hit     = (edge_src == top_v_q) && (CntW'(edge_tgt) < n_eff) &&
                              !visited_q[edge_tgt];
  assign sts_o.last_level   = depth_q == CntW'(1);
  assign sts_o.emit_done    = fin_q == '0;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= VertCap) else $error("walk depth beyond vertex capacity");
  a_fin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q <= VertCap) else $error("finish count beyond vertex capacity");
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_cnt_q <= EdgeCap) else $error("edge count beyond capacity");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_ld |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");
  a_descend_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.descend |=> visited_q[$past(edge_tgt)])
    else $error("descended vertex not marked visited");

endmodule

FILE: sv/dts_ctrl.sv
// controller: sequences edge loads, the depth-first walk and the emit phase
module dts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_i,
  output logic              in_ready_o,
  input  dts_pkg::dp_sts_t  sts_i,
  output dts_pkg::dp_cmd_t  cmd_o
);
  import dts_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRoot  = 3'd1;
  localparam logic [2:0] StFetch = 3'd2;
  localparam logic [2:0] StTest  = 3'd3;
  localparam logic [2:0] StPopRd = 3'd4;
  localparam logic [2:0] StPopLd = 3'd5;
  localparam logic [2:0] StEmRd  = 3'd6;
  localparam logic [2:0] StEmWr  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       in_acc;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_req_i == ReqSort) begin
            cmd_o.clear_walk = 1'b1;
            state_d          = StRoot;
          end else begin
            cmd_o.load_edge = 1'b1;
          end
        end
      end
      StRoot: begin
        if (sts_i.root_done) begin
          state_d = StEmRd;
        end else if (sts_i.root_visited) begin
          cmd_o.root_next = 1'b1;
        end else begin
          cmd_o.root_start = 1'b1;
          state_d          = StFetch;
        end
      end
      StFetch: begin
        if (sts_i.scan_end) begin
          cmd_o.finish = 1'b1;
          state_d      = sts_i.last_level ? StRoot : StPopRd;
        end else begin
          cmd_o.fetch = 1'b1;
          state_d     = StTest;
        end
      end
      StTest: begin
        if (sts_i.edge_hit) begin
          cmd_o.descend = 1'b1;
        end else begin
          cmd_o.skip = 1'b1;
        end
        state_d = StFetch;
      end
      StPopRd: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = StPopLd;
      end
      StPopLd: begin
        cmd_o.pop_ld = 1'b1;
        state_d      = StFetch;
      end
      StEmRd: begin
        if (sts_i.emit_done) begin
          state_d = StIdle;
        end else begin
          cmd_o.emit_rd = 1'b1;
          state_d       = StEmWr;
        end
      end
      StEmWr: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d       = StEmRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_edge |-> (state_q == StIdle))
    else $error("edge load outside idle");
  a_pop_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop_rd |=> cmd_o.pop_ld) else $error("pop read not followed by load");
  a_emit_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_rd |=> (state_q == StEmWr)) else $error("emit read lost");

endmodule

FILE: sv/dfs_topological_sort.sv
// top level: depth-first topological sort with apb vertex count register
// add-edge item: accepted back to back while idle; no result
// sort item: roots are scanned in order, each unvisited root starts a walk, stored edges
//   are tested through one edge store read port (each stored edge tested once per visited
//   vertex), finished vertices pop the stack, then result items go out as the output frees
// reset: edge count, drop flag and visited marks clear, vertex count reads 64
module dfs_topological_sort #(
  parameter int unsigned MAX_EDGES = dts_pkg::DefMaxEdges
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dts_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dts_pkg::*;

  logic [CntW-1:0] vcount_q;
  logic            reg_sel;
  dp_cmd_t         cmd;
  dp_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == RegVertexCount);

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VertexCountReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      vcount_q <= pwdata[CntW-1:0];
    end
  end

  // register read
  assign prdata = reg_sel ? {{(32-CntW){1'b0}}, vcount_q} : '0;

  dts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_item_i.req_type),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dts_dp #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .vcount_i    (vcount_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
